### hdl/bqbp_pkg.sv
// Package for the biquad band-pass filter: sample and coefficient widths,
// register indexes and the packed types of the item and configuration buses.
// No dependencies.
`default_nettype none

package bqbp_pkg;

   localparam int SAMPLE_BITS            = 16;
   localparam int COEF_BITS              = 18;
   localparam int COEF_FRAC_BITS_DEFAULT = 14;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = COEF_BITS;

   localparam logic [CSR_ADDR_BITS-1:0] REG_FILTER_ENABLE = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COEF_B0       = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COEF_B1       = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COEF_B2       = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COEF_A1       = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_COEF_A2       = 3'd5;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_in;
      logic                          block_last_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_out;
      logic                          block_last_out;
   } rsp_type;

   // Filter settings as seen by the datapath, plus the history clear strobe.
   typedef struct packed {
      logic                        enable;
      logic                        hist_clear;
      logic signed [COEF_BITS-1:0] coef_b0;
      logic signed [COEF_BITS-1:0] coef_b1;
      logic signed [COEF_BITS-1:0] coef_b2;
      logic signed [COEF_BITS-1:0] coef_a1;
      logic signed [COEF_BITS-1:0] coef_a2;
   } cfg_type;

endpackage

`default_nettype wire

### hdl/bqbp_csr.sv
// Configuration registers of the biquad band-pass filter: enable and the five
// Q-format coefficients. Depends on bqbp_pkg.
`default_nettype none

module bqbp_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_wen,
   input  wire logic [bqbp_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [bqbp_pkg::CSR_DATA_BITS-1:0]  csr_wdata,
   output bqbp_pkg::cfg_type                        cfg
);
   import bqbp_pkg::*;

   logic                 enable_ff, enable_in;
   logic [COEF_BITS-1:0] b0_ff, b0_in;
   logic [COEF_BITS-1:0] b1_ff, b1_in;
   logic [COEF_BITS-1:0] b2_ff, b2_in;
   logic [COEF_BITS-1:0] a1_ff, a1_in;
   logic [COEF_BITS-1:0] a2_ff, a2_in;
   logic                 hit;

   always_comb begin
      enable_in = enable_ff;
      b0_in     = b0_ff;
      b1_in     = b1_ff;
      b2_in     = b2_ff;
      a1_in     = a1_ff;
      a2_in     = a2_ff;
      hit       = 1'b0;
      if (csr_wen) begin
         hit = 1'b1;
         case (csr_addr)
            REG_FILTER_ENABLE: enable_in = csr_wdata[0];
            REG_COEF_B0:       b0_in     = csr_wdata[COEF_BITS-1:0];
            REG_COEF_B1:       b1_in     = csr_wdata[COEF_BITS-1:0];
            REG_COEF_B2:       b2_in     = csr_wdata[COEF_BITS-1:0];
            REG_COEF_A1:       a1_in     = csr_wdata[COEF_BITS-1:0];
            REG_COEF_A2:       a2_in     = csr_wdata[COEF_BITS-1:0];
            default:           hit       = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         b0_ff     <= '0;
         b1_ff     <= '0;
         b2_ff     <= '0;
         a1_ff     <= '0;
         a2_ff     <= '0;
      end else begin
         enable_ff <= enable_in;
         b0_ff     <= b0_in;
         b1_ff     <= b1_in;
         b2_ff     <= b2_in;
         a1_ff     <= a1_in;
         a2_ff     <= a2_in;
      end
   end

   // Any write to a defined register, even with the same value, restarts
   // the filter from a clean history at the same edge.
   assign cfg.enable     = enable_ff;
   assign cfg.hist_clear = hit;
   assign cfg.coef_b0    = b0_ff;
   assign cfg.coef_b1    = b1_ff;
   assign cfg.coef_b2    = b2_ff;
   assign cfg.coef_a1    = a1_ff;
   assign cfg.coef_a2    = a2_ff;

endmodule

`default_nettype wire

### hdl/bqbp_datapath.sv
// Biquad arithmetic: five products, sum, truncation toward zero, saturation,
// and the input and output history registers. Depends on bqbp_pkg.
`default_nettype none

module bqbp_datapath #(
   parameter int COEF_FRAC_BITS = bqbp_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  bqbp_pkg::cfg_type                          cfg,
   input  wire logic                                  step,
   input  wire logic signed [bqbp_pkg::SAMPLE_BITS-1:0] x_in,
   output logic signed [bqbp_pkg::SAMPLE_BITS-1:0]    y_out
);
   import bqbp_pkg::*;

   localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
   localparam int ACC_W  = PROD_W + 3;
   localparam logic [ACC_W-1:0] TRUNC_BIAS =
      {{(ACC_W-COEF_FRAC_BITS){1'b0}}, {COEF_FRAC_BITS{1'b1}}};
   localparam logic signed [ACC_W-1:0] LIM_HI =
      ACC_W'({1'b0, {(SAMPLE_BITS-1){1'b1}}});
   localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);

   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in, x2_ff, x2_in;
   logic signed [SAMPLE_BITS-1:0] y1_ff, y1_in, y2_ff, y2_in;
   logic signed [COEF_BITS-1:0]   cb0, cb1, cb2, ca1, ca2;
   logic signed [PROD_W-1:0]      p0, p1, p2, p3, p4;
   logic signed [ACC_W-1:0]       acc, acc_adj, quot;
   logic signed [SAMPLE_BITS-1:0] y_filt;

   assign cb0 = cfg.coef_b0;
   assign cb1 = cfg.coef_b1;
   assign cb2 = cfg.coef_b2;
   assign ca1 = cfg.coef_a1;
   assign ca2 = cfg.coef_a2;

   always_comb begin
      p0 = x_in  * cb0;
      p1 = x1_ff * cb1;
      p2 = x2_ff * cb2;
      p3 = y1_ff * ca1;
      p4 = y2_ff * ca2;
      acc = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) - ACC_W'(p3) - ACC_W'(p4);
      // A negative sum is biased up so the arithmetic shift rounds toward zero.
      acc_adj = acc + (acc[ACC_W-1] ? signed'(TRUNC_BIAS) : ACC_W'(0));
      quot    = acc_adj >>> COEF_FRAC_BITS;
      if (quot > LIM_HI) begin
         y_filt = LIM_HI[SAMPLE_BITS-1:0];
      end else if (quot < LIM_LO) begin
         y_filt = LIM_LO[SAMPLE_BITS-1:0];
      end else begin
         y_filt = quot[SAMPLE_BITS-1:0];
      end
      y_out = cfg.enable ? y_filt : x_in;
   end

   always_comb begin
      x1_in = x1_ff;
      x2_in = x2_ff;
      y1_in = y1_ff;
      y2_in = y2_ff;
      if (cfg.hist_clear) begin
         x1_in = '0;
         x2_in = '0;
         y1_in = '0;
         y2_in = '0;
      end else if (step && cfg.enable) begin
         x1_in = x_in;
         x2_in = x1_ff;
         y1_in = y_filt;
         y2_in = y1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x1_ff <= '0;
         x2_ff <= '0;
         y1_ff <= '0;
         y2_ff <= '0;
      end else begin
         x1_ff <= x1_in;
         x2_ff <= x2_in;
         y1_ff <= y1_in;
         y2_ff <= y2_in;
      end
   end

endmodule

`default_nettype wire

### hdl/biquad_bandpass_filter.sv
// Biquad band-pass filter, direct form I, one sample per item.
// Input channel req_*: valid/ready, payload req_data (sample_in, block_last_in).
// Result channel rsp_*: valid/ready, payload rsp_data (sample_out,
// block_last_out), one result per accepted item, in order.
// Configuration: csr_wen/csr_addr/csr_wdata write enable and the coefficients;
// any write to a defined register clears the filter history.
// Pipeline: an accepted item sits in the input register until the result
// register is free; it is then computed and loaded into the result register,
// and rsp_valid rises with it.
// Throughput: one item per cycle while results are taken. The five 16x18
// multipliers and the adder, together with the output history feedback, lie
// between the input register and the result register.
// Stalls: while rsp_ready is low the result holds; the input register still
// takes one more item, then req_ready drops until the result is taken.
// Reset: both pipeline registers empty, configuration registers and history zero,
// filtering disabled (samples pass through).
// Depends on bqbp_pkg, bqbp_csr and bqbp_datapath.
`default_nettype none

module biquad_bandpass_filter #(
   parameter int COEF_FRAC_BITS = bqbp_pkg::COEF_FRAC_BITS_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  bqbp_pkg::req_type                        req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output bqbp_pkg::rsp_type                        rsp_data,
   input  wire logic                                csr_wen,
   input  wire logic [bqbp_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  wire logic [bqbp_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import bqbp_pkg::*;

   cfg_type                       cfg;
   logic                          in_valid_ff, in_valid_in;
   req_type                       in_data_ff, in_data_in;
   logic                          out_valid_ff, out_valid_in;
   rsp_type                       out_data_ff, out_data_in;
   logic                          out_free;
   logic                          advance;
   logic signed [SAMPLE_BITS-1:0] y;

   bqbp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bqbp_datapath #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .step  (advance),
      .x_in  (in_data_ff.sample_in),
      .y_out (y)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (out_free) begin
         out_valid_in = advance;
         if (advance) begin
            out_data_in.sample_out     = y;
            out_data_in.block_last_out = in_data_ff.block_last_in;
         end
      end
      if (req_ready) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_data_in = req_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !in_valid_ff && !out_valid_ff)
      else $error("pipeline not empty after reset");

   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_data_ff))
      else $error("stalled input item lost or changed");

   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("computed item did not reach the result register");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      advance && !cfg.enable |=> out_data_ff.sample_out == $past(in_data_ff.sample_in))
      else $error("bypass result differs from input sample");

   a_marker: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_data_ff.block_last_out == $past(in_data_ff.block_last_in))
      else $error("block marker not carried with its sample");

endmodule

`default_nettype wire
